// File: rtl/fcull_pkg.sv
package fcull_pkg;

	// Matrix geometry: 4x4, column-major, index = column*4 + row
	localparam int unsigned MAT_DIM   = 4;
	localparam int unsigned MAT_ELEMS = MAT_DIM * MAT_DIM;
	localparam int unsigned MAT_IDX_W = $clog2(MAT_ELEMS);
	localparam int unsigned NUM_PLANES = 6;
	localparam int unsigned NUM_AXES   = 3;

	// Q16.16 inputs, Q17.16 plane terms, Q33.32 products, Q34.32 pair sums and Q35.32 totals
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned NRM_W  = VAL_W + 1;
	localparam int unsigned PROD_W = NRM_W + VAL_W;
	localparam int unsigned CNST_W = NRM_W + 16;
	localparam int unsigned PAIR_W = PROD_W + 1;
	localparam int unsigned SUM_W  = PAIR_W + 1;
	localparam int unsigned CNT_W  = 3;

	localparam logic [CNT_W-1:0] ALL_PLANES = CNT_W'(NUM_PLANES);

	// Request command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef struct packed {
		logic                       command;
		logic [MAT_IDX_W-1:0]       element_index;
		logic signed [VAL_W-1:0]    element_value;
		logic signed [VAL_W-1:0]    box_min_x;
		logic signed [VAL_W-1:0]    box_min_y;
		logic signed [VAL_W-1:0]    box_min_z;
		logic signed [VAL_W-1:0]    box_max_x;
		logic signed [VAL_W-1:0]    box_max_y;
		logic signed [VAL_W-1:0]    box_max_z;
	} req_t;

	typedef struct packed {
		logic             visible;
		logic [CNT_W-1:0] planes_passed;
	} rsp_t;

	// Head of the request queue as seen by the back end
	typedef struct packed {
		logic valid;
		logic is_test;
		req_t req;
	} q_head_t;

endpackage

// File: rtl/fcull_queue.sv
module fcull_queue
	import fcull_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  req_t    req,
	output q_head_t head,
	input  logic    pop
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

	req_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              push;
	logic              do_pop;

	assign req_ready = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign push      = req_valid && req_ready;
	assign do_pop    = pop && (count_q != '0);

	// Classify the request at the head for the back end
	always_comb begin
		head.valid   = (count_q != '0);
		head.req     = mem_q[rd_ptr_q];
		head.is_test = (mem_q[rd_ptr_q].command == CMD_TEST);
	end

	// Store accepted requests
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= req;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QUEUE_DEPTH))
		else $error("queue occupancy above depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");
`endif

endmodule

// File: rtl/fcull_back.sv
module fcull_back
	import fcull_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    pop,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output rsp_t    rsp
);

	logic signed [VAL_W-1:0]  matrix_q [MAT_ELEMS];

	logic                     en;
	logic                     issue_test;
	logic                     issue_load;

	logic signed [NRM_W-1:0]  n_c  [NUM_PLANES][NUM_AXES];
	logic signed [VAL_W-1:0]  p_c  [NUM_PLANES][NUM_AXES];
	logic signed [NRM_W-1:0]  d_c  [NUM_PLANES];
	logic signed [VAL_W-1:0]  bmin [NUM_AXES];
	logic signed [VAL_W-1:0]  bmax [NUM_AXES];

	logic                     v_s1;
	logic signed [NRM_W-1:0]  n_s1 [NUM_PLANES][NUM_AXES];
	logic signed [VAL_W-1:0]  p_s1 [NUM_PLANES][NUM_AXES];
	logic signed [NRM_W-1:0]  d_s1 [NUM_PLANES];

	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2 [NUM_PLANES][NUM_AXES];
	logic signed [CNST_W-1:0] cnst_s2 [NUM_PLANES];

	logic                     v_s3;
	logic signed [PAIR_W-1:0] sa_s3 [NUM_PLANES];
	logic signed [PAIR_W-1:0] sb_s3 [NUM_PLANES];

	logic [NUM_PLANES-1:0]    pass_c;
	logic [CNT_W-1:0]         passed_c;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	// Whole back end holds while a result waits on a stalled receiver
	assign en         = !rsp_valid_q || rsp_ready;
	assign pop        = en && head.valid;
	assign issue_test = pop && head.is_test;
	assign issue_load = pop && !head.is_test;

	assign bmin[0] = head.req.box_min_x;
	assign bmin[1] = head.req.box_min_y;
	assign bmin[2] = head.req.box_min_z;
	assign bmax[0] = head.req.box_max_x;
	assign bmax[1] = head.req.box_max_y;
	assign bmax[2] = head.req.box_max_z;

	// Extract planes: row 3 plus or minus row k, pick far corner
	always_comb begin
		for (int pl = 0; pl < NUM_PLANES; pl++) begin
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				if ((pl % 2) == 0) begin
					n_c[pl][ax] = NRM_W'(matrix_q[ax*MAT_DIM + 3])
						+ NRM_W'(matrix_q[ax*MAT_DIM + pl/2]);
				end else begin
					n_c[pl][ax] = NRM_W'(matrix_q[ax*MAT_DIM + 3])
						- NRM_W'(matrix_q[ax*MAT_DIM + pl/2]);
				end
				p_c[pl][ax] = n_c[pl][ax][NRM_W-1] ? bmin[ax] : bmax[ax];
			end
			if ((pl % 2) == 0) begin
				d_c[pl] = NRM_W'(matrix_q[3*MAT_DIM + 3]) + NRM_W'(matrix_q[3*MAT_DIM + pl/2]);
			end else begin
				d_c[pl] = NRM_W'(matrix_q[3*MAT_DIM + 3]) - NRM_W'(matrix_q[3*MAT_DIM + pl/2]);
			end
		end
	end

	// Write matrix elements in request order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_ELEMS; i++) begin
				matrix_q[i] <= '0;
			end
		end else if (issue_load) begin
			matrix_q[head.req.element_index] <= head.req.element_value;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= issue_test;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			rsp_valid_q <= v_s3;
		end
	end

	// Stage 1: plane terms and chosen corner
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= n_c;
			p_s1 <= p_c;
			d_s1 <= d_c;
		end
	end

	// Stage 2: one multiplier per plane axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int pl = 0; pl < NUM_PLANES; pl++) begin
				for (int ax = 0; ax < NUM_AXES; ax++) begin
					prod_s2[pl][ax] <= PROD_W'(n_s1[pl][ax]) * PROD_W'(p_s1[pl][ax]);
				end
				cnst_s2[pl] <= {d_s1[pl], 16'h0000};
			end
		end
	end

	// Stage 3: pair sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int pl = 0; pl < NUM_PLANES; pl++) begin
				sa_s3[pl] <= PAIR_W'(prod_s2[pl][0]) + PAIR_W'(prod_s2[pl][1]);
				sb_s3[pl] <= PAIR_W'(prod_s2[pl][2]) + PAIR_W'(cnst_s2[pl]);
			end
		end
	end

	// Final distance sign and pass count
	always_comb begin
		logic signed [SUM_W-1:0] total;
		passed_c = '0;
		for (int pl = 0; pl < NUM_PLANES; pl++) begin
			total      = SUM_W'(sa_s3[pl]) + SUM_W'(sb_s3[pl]);
			pass_c[pl] = !total[SUM_W-1];
			passed_c   = passed_c + CNT_W'(pass_c[pl]);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.visible       <= (passed_c == ALL_PLANES);
			rsp_q.planes_passed <= passed_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (v_s1 == $past(v_s1)) && (v_s2 == $past(v_s2)) && (v_s3 == $past(v_s3)))
		else $error("pipeline moved during a stall");

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en) |=> rsp_valid)
		else $error("result lost between last stage and output");

	a_no_load_write_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> !pop)
		else $error("queue popped while back end stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.planes_passed <= ALL_PLANES))
		else $error("plane count out of range");
`endif

endmodule

// File: rtl/frustum_box_cull_top.sv
// Frustum culling of axis-aligned boxes against a stored projection-view matrix.
// Request channel (req_valid/req_ready/req): command CMD_LOAD writes one Q16.16
// element of the column-major 4x4 matrix at element_index and gives no
// response; command CMD_TEST tests the box given by its min and max corners.
// Response channel (rsp_valid/rsp_ready/rsp): one response per test request,
// in request order, with planes_passed (0..6) and visible (all six passed).
// A request is queued in a QUEUE_DEPTH-entry queue; the back end pops one
// request per cycle while the receiver does not stall and runs it through
// three registered stages (plane terms, products, pair sums) into the output
// register. Throughput is one request per cycle while rsp is not stalled,
// set by the per-axis multiplier lanes of the back end. Loads take effect in
// order, so each test sees all loads accepted before it.
// Reset clears the matrix to zero, empties the queue and drops any response.
// When the receiver stalls, the back end holds in place and the queue keeps
// accepting requests until it is full.
module frustum_box_cull_top
	import fcull_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	q_head_t head;
	logic    pop;

	fcull_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.head      (head),
		.pop       (pop)
	);

	fcull_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fcull_pkg::*;

	localparam logic signed [VAL_W-1:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [VAL_W-1:0] Q_HALF = 32'sh0000_8000;
	localparam logic signed [VAL_W-1:0] Q_MAX  = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] Q_MIN  = 32'sh8000_0000;
	localparam int unsigned ITEM_TARGET = 1550;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow copy of the matrix store, updated as requests are accepted
	logic signed [VAL_W-1:0] shadow_mat [MAT_ELEMS] = '{default: '0};
	req_t pending [$];
	rsp_t verdicts [$];
	rsp_t want_rsp;
	int errors = 0;

	int send_gap = 0;
	int send_run = 0;
	bit send_calm = 1'b0;
	int take_gap = 0;
	int take_run = 0;
	bit take_calm = 1'b0;

	frustum_box_cull_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic longint mat_at(int col, int row);
		return longint'(shadow_mat[col * MAT_DIM + row]);
	endfunction

	// Cull one box against the six planes taken from the shadow matrix
	function automatic rsp_t cull_box(req_t r);
		longint lo [NUM_AXES];
		longint hi [NUM_AXES];
		longint nrm;
		longint cnst;
		longint corner;
		logic signed [127:0] plane_sum;
		logic signed [127:0] wn;
		logic signed [127:0] wc;
		int k;
		bit plus;
		int unsigned passed;
		rsp_t res;
		lo[0] = r.box_min_x;
		lo[1] = r.box_min_y;
		lo[2] = r.box_min_z;
		hi[0] = r.box_max_x;
		hi[1] = r.box_max_y;
		hi[2] = r.box_max_z;
		passed = 0;
		for (int p = 0; p < NUM_PLANES; p++) begin
			k = p / 2;
			plus = (p % 2) == 0;
			cnst = plus ? mat_at(3, 3) + mat_at(3, k) : mat_at(3, 3) - mat_at(3, k);
			plane_sum = cnst;
			plane_sum = plane_sum <<< 16;
			for (int c = 0; c < NUM_AXES; c++) begin
				nrm = plus ? mat_at(c, 3) + mat_at(c, k) : mat_at(c, 3) - mat_at(c, k);
				// take the corner farthest along the normal
				corner = (nrm >= 0) ? hi[c] : lo[c];
				wn = nrm;
				wc = corner;
				plane_sum = plane_sum + wn * wc;
			end
			if (!plane_sum[127])
				passed++;
		end
		res.planes_passed = passed[CNT_W-1:0];
		res.visible = (passed == NUM_PLANES);
		return res;
	endfunction

	// Apply an accepted request to the shadow state
	function automatic void absorb(req_t r);
		if (r.command == CMD_LOAD)
			shadow_mat[r.element_index] = r.element_value;
		else
			verdicts.push_back(cull_box(r));
	endfunction

	// Idle length: mostly short, a few long, with calm stretches of none
	function automatic int next_gap(inout int run, inout bit calm);
		int unsigned r;
		if (run == 0) begin
			run = $urandom_range(8, 80);
			calm = ($urandom_range(0, 3) == 0);
		end
		run--;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return 32'sd1;
			4: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_elem(int style, int idx);
		case (style)
			0: return $urandom;
			1: begin
				// near-identity matrix so that boxes straddle the planes
				if (idx % 5 == 0)
					return Q_ONE + (int'($urandom_range(0, 32768)) - 16384);
				if ($urandom_range(0, 3) == 0)
					return '0;
				return int'($urandom_range(0, 16384)) - 8192;
			end
			2: return $signed($urandom) >>> $urandom_range(0, 31);
			default: return pick_extreme();
		endcase
	endfunction

	task automatic push_load(input int idx, input logic signed [VAL_W-1:0] val);
		req_t r;
		r.command = CMD_LOAD;
		r.element_index = idx[MAT_IDX_W-1:0];
		r.element_value = val;
		// fill the ignored box fields with noise
		r.box_min_x = $urandom;
		r.box_min_y = $urandom;
		r.box_min_z = $urandom;
		r.box_max_x = $urandom;
		r.box_max_y = $urandom;
		r.box_max_z = $urandom;
		pending.push_back(r);
	endtask

	task automatic push_test(input logic signed [VAL_W-1:0] lx, ly, lz, hx, hy, hz);
		req_t r;
		r.command = CMD_TEST;
		r.element_index = MAT_IDX_W'($urandom);
		r.element_value = $urandom;
		r.box_min_x = lx;
		r.box_min_y = ly;
		r.box_min_z = lz;
		r.box_max_x = hx;
		r.box_max_y = hy;
		r.box_max_z = hz;
		pending.push_back(r);
	endtask

	// Request driver: hold each request until accepted, then idle at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready)
				absorb(req);
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					req_valid <= 1'b1;
					req <= pending.pop_front();
					send_gap = next_gap(send_run, send_calm);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: check each accepted response, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (verdicts.size() == 0) begin
					errors++;
					$display("%0t: response with none pending: visible=%0b planes_passed=%0d",
						$time, rsp.visible, rsp.planes_passed);
				end else begin
					want_rsp = verdicts.pop_front();
					if (rsp.visible !== want_rsp.visible) begin
						errors++;
						$display("%0t: visible expected %0b got %0b",
							$time, want_rsp.visible, rsp.visible);
					end
					if (rsp.planes_passed !== want_rsp.planes_passed) begin
						errors++;
						$display("%0t: planes_passed expected %0d got %0d",
							$time, want_rsp.planes_passed, rsp.planes_passed);
					end
				end
			end
			if (take_gap > 0) begin
				take_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				take_gap = next_gap(take_run, take_calm);
			end
		end
	end

	// Stimulus, reset and drain
	initial begin
		int style;
		int box_style;
		int idx;
		int ctr;
		int half;
		logic signed [VAL_W-1:0] lo [NUM_AXES];
		logic signed [VAL_W-1:0] hi [NUM_AXES];
		logic signed [VAL_W-1:0] tmp;

		// unloaded matrix: every distance is zero, so any box is visible
		push_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
		push_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
		// identity matrix: frustum is the cube from -1 to 1
		for (int i = 0; i < MAT_DIM; i++)
			push_load(i * 5, Q_ONE);
		push_test(-Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF);
		push_test(2 * Q_ONE, '0, '0, 3 * Q_ONE, Q_HALF, Q_HALF);
		push_test(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
		// min above max on x, used as given
		push_test(Q_HALF, -Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF);
		// zero normal components pick the max corner; extreme min must not matter
		push_test(-Q_HALF, Q_MIN, -Q_HALF, Q_HALF, Q_HALF, Q_HALF);
		// extreme matrix elements and boxes stress the wide sums
		push_load(15, Q_MIN);
		push_load(12, Q_MAX);
		push_load(3, Q_MIN);
		push_load(0, Q_MAX);
		push_load(9, -32'sd1);
		push_load(7, Q_MAX);
		push_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
		push_test(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
		push_test('0, '0, '0, '0, '0, '0);

		// random scenes: load a matrix, then test a run of boxes against it
		while (pending.size() < ITEM_TARGET) begin
			style = $urandom_range(0, 3);
			if (style == 1 || $urandom_range(0, 1) == 0) begin
				for (int i = 0; i < MAT_ELEMS; i++)
					push_load(i, rand_elem(style, i));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					idx = $urandom_range(0, MAT_ELEMS - 1);
					push_load(idx, rand_elem(style, idx));
				end
			end
			box_style = $urandom_range(0, 3);
			repeat ($urandom_range(5, 30)) begin
				if ($urandom_range(0, 19) == 0) begin
					// stray load in the middle of a run
					push_load($urandom_range(0, MAT_ELEMS - 1), $urandom);
				end else begin
					for (int a = 0; a < NUM_AXES; a++) begin
						case (box_style)
							0, 1: begin
								ctr = int'($urandom_range(0, 262144)) - 131072;
								half = $urandom_range(0, 65536);
								lo[a] = ctr - half;
								hi[a] = ctr + half;
								if ($urandom_range(0, 9) == 0) begin
									tmp = lo[a];
									lo[a] = hi[a];
									hi[a] = tmp;
								end
							end
							2: begin
								lo[a] = $urandom;
								hi[a] = $urandom;
							end
							default: begin
								lo[a] = pick_extreme();
								hi[a] = pick_extreme();
							end
						endcase
					end
					push_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || req_valid || verdicts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Hang guard
	initial begin
		#20ms;
		$display("tb: errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/fcull_pkg.sv
rtl/fcull_queue.sv
rtl/fcull_back.sv
rtl/frustum_box_cull_top.sv
tb/tb.sv
